// ----- hdl/gbl_pkg.sv -----
// ----------------------------------------------------------------------------
// gbl_pkg
// Shared types, constants and pin-mixing helpers for the bit-banged LCD
// controller core.
// ----------------------------------------------------------------------------
package gbl_pkg;

   // Bus phases of the LCD strobe decoder.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_READY  = 3'd1,
      PH_CMD_W  = 3'd2,
      PH_STAT_R = 3'd3,
      PH_DATA_W = 3'd4,
      PH_DATA_R = 3'd5
   } phase_type;

   // Register access codes.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] REG_PORT_D = 2'd0;
   localparam logic [1:0] REG_DIR    = 2'd1;
   localparam logic [1:0] REG_PORT_E = 2'd2;

   // Port D strobe bit positions.
   localparam int unsigned BIT_WR  = 0;
   localparam int unsigned BIT_SEL = 4;
   localparam int unsigned BIT_DC  = 6;
   localparam int unsigned BIT_EN  = 7;

   // Busy flag in the status byte on port E.
   localparam logic [7:0] STATUS_BUSY = 8'h10;

   // LCD command codes.
   localparam logic [7:0] CMD_CONTRAST    = 8'h81;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'hae;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'haf;
   localparam logic [7:0] CMD_RMW_ENTER   = 8'he0;
   localparam logic [7:0] CMD_RMW_EXIT    = 8'hee;
   localparam logic [3:0] CMD_GRP_PAGE    = 4'hb;
   localparam logic [3:0] CMD_GRP_COL_HI  = 4'h1;
   localparam logic [3:0] CMD_GRP_COL_LO  = 4'h0;

   // Reset values.
   localparam logic [5:0] CONTRAST_RESET = 6'd38;
   localparam logic [7:0] LATCH_RESET    = 8'hff;
   localparam logic [7:0] DIR_RESET      = 8'h33;

   // Actions that one port D write asks of the datapath.
   typedef struct packed {
      logic cmd_run;
      logic stat_clear;
      logic data_load;
      logic data_store;
      logic primed_set;
   } bus_action_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] read_data;
      logic       display_on;
      logic [5:0] contrast_level;
   } rsp_type;

   // Nibble mask selected by a two-bit code.
   function automatic logic [7:0] nibble_mask(input logic [1:0] code);
      logic [7:0] m;
      case (code)
         2'd1:    m = 8'h0f;
         2'd2:    m = 8'hf0;
         2'd3:    m = 8'hff;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // Pins seen on a port: forced levels where the port is input, else latch.
   function automatic logic [7:0] mix_pins(input logic [7:0] latch,
                                           input logic [1:0] in_code,
                                           input logic [1:0] lvl_code);
      logic [7:0] m;
      m = nibble_mask(in_code);
      return (nibble_mask(lvl_code) & m) | (latch & ~m);
   endfunction

endpackage

// ----- hdl/gpio_bitbang_lcd_controller_core.sv -----
// ----------------------------------------------------------------------------
// gpio_bitbang_lcd_controller_core
// GPIO register front end of a bit-banged graphic LCD controller with a
// page/column frame store.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  operation, register_select,
//                                            write_data
//   rsp      out        rsp_valid/rsp_stall  read_data, display_on,
//                                            contrast_level
//
// One transaction is accepted per cycle while req_stall is low; its result is registered in the result queue.
// A data read fetches the frame store over the registered RAM read port and
// the fetched byte is forwarded to the next transaction, so it never stalls.
// After reset the frame store is cleared one entry a cycle, over all
// PAGE_COUNT * COLUMN_COUNT entries (1536 by default), with req_stall high.
// A two-entry result queue keeps accepting until it is full while rsp_stall holds a result.
// ----------------------------------------------------------------------------
module gpio_bitbang_lcd_controller_core #(
   parameter int PAGE_COUNT   = 8,
   parameter int COLUMN_COUNT = 192
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [1:0] req_register_select,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_display_on,
   output logic [5:0] rsp_contrast_level
);

   localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic             accept;
   logic             busy;
   logic             full;
   gbl_pkg::rsp_type result;
   gbl_pkg::rsp_type rsp_data;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;

   // Input handshake.
   assign req_stall = busy || full;
   assign accept    = req_valid && !req_stall;

   // Register file, bus decoder and frame store sequencing.
   gbl_engine #(
      .PAGE_COUNT   (PAGE_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_operation       (req_operation),
      .req_register_select (req_register_select),
      .req_write_data      (req_write_data),
      .result              (result),
      .busy                (busy),
      .ram_we              (ram_we),
      .ram_waddr           (ram_waddr),
      .ram_wdata           (ram_wdata),
      .ram_re              (ram_re),
      .ram_raddr           (ram_raddr),
      .ram_rdata           (ram_rdata)
   );

   // Frame store.
   gbl_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Result queue.
   gbl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_read_data      = rsp_data.read_data;
   assign rsp_display_on     = rsp_data.display_on;
   assign rsp_contrast_level = rsp_data.contrast_level;

endmodule

// ----- hdl/gbl_ram.sv -----
// ----------------------------------------------------------------------------
// gbl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module gbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ----- hdl/gbl_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// gbl_rsp_queue
// Two-entry result queue that decouples the engine from the result channel.
// ----------------------------------------------------------------------------
module gbl_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gbl_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gbl_pkg::rsp_type rsp_data
);

   logic [1:0]       count_ff, count_in;
   gbl_pkg::rsp_type slot0_ff, slot0_in;
   gbl_pkg::rsp_type slot1_ff, slot1_in;
   logic             pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   // Queue update for push, pop or both.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload slots.
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // The queue never holds more than two results.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   // A push into a full queue must come with a pop.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("result queue overflow");

endmodule

// ----- hdl/gbl_engine.sv -----
// ----------------------------------------------------------------------------
// gbl_engine
// GPIO register file, pin mixing, LCD bus-phase decoder, command decoder and
// frame store access sequencing, including the clearing pass after reset.
// ----------------------------------------------------------------------------
module gbl_engine #(
   parameter int PAGE_COUNT   = 8,
   parameter int COLUMN_COUNT = 192,
   localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             req_operation,
   input  logic [1:0]       req_register_select,
   input  logic [7:0]       req_write_data,
   output gbl_pkg::rsp_type result,
   output logic             busy,
   output logic             ram_we,
   output logic [AW-1:0]    ram_waddr,
   output logic [7:0]       ram_wdata,
   output logic             ram_re,
   output logic [AW-1:0]    ram_raddr,
   input  logic [7:0]       ram_rdata
);

   // Register state.
   gbl_pkg::phase_type phase_ff, phase_in;
   logic [7:0] d_latch_ff, d_latch_in;
   logic [7:0] e_latch_ff, e_latch_in;
   logic [7:0] dir_ff, dir_in;
   logic [7:0] e_pins_ff, e_pins_in;
   logic       load_pend_ff, load_pend_in;
   logic [7:0] page_ff, page_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] saved_col_ff, saved_col_in;
   logic       rmw_ff, rmw_in;
   logic       primed_ff, primed_in;
   logic [5:0] contrast_ff, contrast_in;
   logic       contrast_exp_ff, contrast_exp_in;
   logic       display_ff, display_in;
   logic       clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Working signals.
   gbl_pkg::bus_action_type act;
   logic [7:0]    e_eff;
   logic [7:0]    d_mix;
   logic [7:0]    e_mix;
   logic [7:0]    bus_pins;
   logic          bus_go;
   logic          addr_ok;
   logic [AW-1:0] store_addr;
   logic [7:0]    col_adv;
   logic [7:0]    page_adv;
   logic [7:0]    rd;
   logic          item_we;
   logic          item_re;

   // Port E pins take the frame store data in the cycle after a data read.
   assign e_eff = load_pend_ff ? ram_rdata : e_pins_ff;

   // Pins as mixed from the current latches and control byte.
   assign d_mix = gbl_pkg::mix_pins(d_latch_ff, dir_ff[1:0], dir_ff[3:2]);
   assign e_mix = gbl_pkg::mix_pins(e_latch_ff, dir_ff[5:4], dir_ff[7:6]);

   // Port D pins after a port D write; these drive the bus decoder.
   assign bus_pins = gbl_pkg::mix_pins(req_write_data, dir_ff[1:0], dir_ff[3:2]);
   assign bus_go   = accept && (req_operation == gbl_pkg::OP_WRITE) &&
                     (req_register_select == gbl_pkg::REG_PORT_D);

   // Frame store address and range check.
   assign addr_ok    = (page_ff < 8'(PAGE_COUNT)) &&
                       ({1'b0, col_ff} < 9'(COLUMN_COUNT));
   assign store_addr = AW'(int'(page_ff) * COLUMN_COUNT + int'(col_ff));

   // Column advance with wrap into the next page.
   always_comb begin
      if (({1'b0, col_ff} + 9'd1) < 9'(COLUMN_COUNT)) begin
         col_adv  = col_ff + 8'd1;
         page_adv = page_ff;
      end else begin
         col_adv  = 8'd0;
         page_adv = page_ff + 8'd1;
      end
   end

   // Bus phase: next state.
   always_comb begin
      phase_in = phase_ff;
      if (bus_go) begin
         unique case (phase_ff)
            gbl_pkg::PH_IDLE: begin
               if (!bus_pins[gbl_pkg::BIT_SEL]) phase_in = gbl_pkg::PH_READY;
            end
            gbl_pkg::PH_READY: begin
               if (bus_pins[gbl_pkg::BIT_SEL]) begin
                  phase_in = gbl_pkg::PH_IDLE;
               end else if (bus_pins[gbl_pkg::BIT_DC]) begin
                  if (bus_pins[gbl_pkg::BIT_WR]) begin
                     if (!bus_pins[gbl_pkg::BIT_EN]) phase_in = gbl_pkg::PH_DATA_W;
                  end else if (bus_pins[gbl_pkg::BIT_EN]) begin
                     phase_in = gbl_pkg::PH_DATA_R;
                  end
               end else if (bus_pins[gbl_pkg::BIT_WR]) begin
                  if (!bus_pins[gbl_pkg::BIT_EN]) phase_in = gbl_pkg::PH_CMD_W;
               end else if (bus_pins[gbl_pkg::BIT_EN]) begin
                  phase_in = gbl_pkg::PH_STAT_R;
               end
            end
            gbl_pkg::PH_CMD_W: begin
               if (bus_pins[gbl_pkg::BIT_EN]) phase_in = gbl_pkg::PH_READY;
            end
            gbl_pkg::PH_STAT_R: begin
               if (bus_pins[gbl_pkg::BIT_WR]) phase_in = gbl_pkg::PH_READY;
            end
            gbl_pkg::PH_DATA_W: begin
               phase_in = gbl_pkg::PH_READY;
            end
            gbl_pkg::PH_DATA_R: begin
               if (bus_pins[gbl_pkg::BIT_WR]) phase_in = gbl_pkg::PH_READY;
            end
            default: begin
               phase_in = gbl_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Bus phase: actions requested of the datapath.
   always_comb begin
      act = '0;
      if (bus_go) begin
         unique case (phase_ff)
            gbl_pkg::PH_READY: begin
               if (!bus_pins[gbl_pkg::BIT_SEL] && !bus_pins[gbl_pkg::BIT_WR] &&
                   bus_pins[gbl_pkg::BIT_EN]) begin
                  act.data_load  = bus_pins[gbl_pkg::BIT_DC];
                  act.stat_clear = !bus_pins[gbl_pkg::BIT_DC];
               end
            end
            gbl_pkg::PH_CMD_W: begin
               act.cmd_run = bus_pins[gbl_pkg::BIT_EN];
            end
            gbl_pkg::PH_DATA_W: begin
               act.data_store = !bus_pins[gbl_pkg::BIT_SEL] &&
                                bus_pins[gbl_pkg::BIT_DC] &&
                                bus_pins[gbl_pkg::BIT_WR] &&
                                bus_pins[gbl_pkg::BIT_EN];
            end
            gbl_pkg::PH_DATA_R: begin
               act.primed_set = bus_pins[gbl_pkg::BIT_WR];
            end
            default: begin
            end
         endcase
      end
   end

   // Register access, commands and frame store sequencing.
   always_comb begin
      d_latch_in      = d_latch_ff;
      e_latch_in      = e_latch_ff;
      dir_in          = dir_ff;
      e_pins_in       = e_eff;
      load_pend_in    = 1'b0;
      page_in         = page_ff;
      col_in          = col_ff;
      saved_col_in    = saved_col_ff;
      rmw_in          = rmw_ff;
      primed_in       = primed_ff;
      contrast_in     = contrast_ff;
      contrast_exp_in = contrast_exp_ff;
      display_in      = display_ff;
      rd              = 8'd0;
      item_we         = 1'b0;
      item_re         = 1'b0;
      if (accept) begin
         if (req_operation == gbl_pkg::OP_READ) begin
            case (req_register_select)
               gbl_pkg::REG_PORT_D: rd = d_mix;
               gbl_pkg::REG_DIR:    rd = dir_ff;
               default:             rd = e_eff;
            endcase
         end else begin
            case (req_register_select)
               gbl_pkg::REG_PORT_E: begin
                  e_latch_in = req_write_data;
                  e_pins_in  = gbl_pkg::mix_pins(req_write_data, dir_ff[5:4],
                                                 dir_ff[7:6]);
               end
               gbl_pkg::REG_DIR: begin
                  dir_in    = req_write_data;
                  e_pins_in = gbl_pkg::mix_pins(e_latch_ff, req_write_data[5:4],
                                                req_write_data[7:6]);
               end
               gbl_pkg::REG_PORT_D: begin
                  d_latch_in = req_write_data;
                  e_pins_in  = e_mix;
                  // Status read reports not busy.
                  if (act.stat_clear) begin
                     e_pins_in = e_mix & ~gbl_pkg::STATUS_BUSY;
                  end
                  // Data read loads port E from the frame store.
                  if (act.data_load && primed_ff && addr_ok) begin
                     item_re      = 1'b1;
                     load_pend_in = 1'b1;
                     if (!rmw_ff) begin
                        col_in  = col_adv;
                        page_in = page_adv;
                     end
                  end
                  // Data write stores port E; the column advances regardless.
                  if (act.data_store) begin
                     item_we = addr_ok;
                     col_in  = col_adv;
                     page_in = page_adv;
                  end
                  if (act.primed_set) begin
                     primed_in = 1'b1;
                  end
                  // Command decode on the port E pins.
                  if (act.cmd_run) begin
                     if (contrast_exp_ff) begin
                        contrast_in     = e_mix[5:0];
                        contrast_exp_in = 1'b0;
                     end else if (e_mix == gbl_pkg::CMD_CONTRAST) begin
                        contrast_exp_in = 1'b1;
                     end else if (e_mix[7:4] == gbl_pkg::CMD_GRP_PAGE) begin
                        page_in   = {4'd0, e_mix[3:0]};
                        primed_in = 1'b0;
                     end else if (e_mix[7:4] == gbl_pkg::CMD_GRP_COL_HI) begin
                        col_in    = {e_mix[3:0], col_ff[3:0]};
                        primed_in = 1'b0;
                     end else if (e_mix[7:4] == gbl_pkg::CMD_GRP_COL_LO) begin
                        col_in    = {col_ff[7:4], e_mix[3:0]};
                        primed_in = 1'b0;
                     end else if (e_mix == gbl_pkg::CMD_DISPLAY_OFF ||
                                  e_mix == gbl_pkg::CMD_DISPLAY_ON) begin
                        display_in = (e_mix == gbl_pkg::CMD_DISPLAY_ON);
                     end else if (e_mix == gbl_pkg::CMD_RMW_ENTER) begin
                        saved_col_in = col_ff;
                        rmw_in       = 1'b1;
                        primed_in    = 1'b0;
                     end else if (e_mix == gbl_pkg::CMD_RMW_EXIT && rmw_ff) begin
                        col_in    = saved_col_ff;
                        rmw_in    = 1'b0;
                        primed_in = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Clearing pass over the frame store after reset.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Frame store port control.
   assign ram_we    = clearing_ff || item_we;
   assign ram_waddr = clearing_ff ? clr_addr_ff : store_addr;
   assign ram_wdata = clearing_ff ? 8'd0 : e_mix;
   assign ram_re    = item_re;
   assign ram_raddr = store_addr;
   assign busy      = clearing_ff;

   // Result of this transaction.
   assign result.read_data      = rd;
   assign result.display_on     = display_in;
   assign result.contrast_level = contrast_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= gbl_pkg::PH_IDLE;
         d_latch_ff      <= gbl_pkg::LATCH_RESET;
         e_latch_ff      <= gbl_pkg::LATCH_RESET;
         dir_ff          <= gbl_pkg::DIR_RESET;
         e_pins_ff       <= gbl_pkg::mix_pins(gbl_pkg::LATCH_RESET,
                                              gbl_pkg::DIR_RESET[5:4],
                                              gbl_pkg::DIR_RESET[7:6]);
         load_pend_ff    <= 1'b0;
         page_ff         <= 8'd0;
         col_ff          <= 8'd0;
         saved_col_ff    <= 8'd0;
         rmw_ff          <= 1'b0;
         primed_ff       <= 1'b0;
         contrast_ff     <= gbl_pkg::CONTRAST_RESET;
         contrast_exp_ff <= 1'b0;
         display_ff      <= 1'b0;
         clearing_ff     <= 1'b1;
         clr_addr_ff     <= '0;
      end else begin
         phase_ff        <= phase_in;
         d_latch_ff      <= d_latch_in;
         e_latch_ff      <= e_latch_in;
         dir_ff          <= dir_in;
         e_pins_ff       <= e_pins_in;
         load_pend_ff    <= load_pend_in;
         page_ff         <= page_in;
         col_ff          <= col_in;
         saved_col_ff    <= saved_col_in;
         rmw_ff          <= rmw_in;
         primed_ff       <= primed_in;
         contrast_ff     <= contrast_in;
         contrast_exp_ff <= contrast_exp_in;
         display_ff      <= display_in;
         clearing_ff     <= clearing_in;
         clr_addr_ff     <= clr_addr_in;
      end
   end

   // No transaction reaches the frame store during the clearing pass.
   a_no_access_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !item_re && !item_we)
      else $error("frame store access during clearing pass");

   // A pending port E load always follows a frame store read.
   a_load_follows_read: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> load_pend_ff)
      else $error("frame store read without pending load");

   // A transaction never both reads and writes the frame store.
   a_rw_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(item_re && item_we))
      else $error("frame store read and write in one transaction");

endmodule

// ----- tb/sv/gpio_lcd_mirror_pkg.sv -----
// ----------------------------------------------------------------------------
// gpio_lcd_mirror_pkg
// Cycle-free mirror of the bit-banged LCD controller. It tracks latches,
// pin mixing, the strobe decoder, commands and the frame store, and keeps
// the queue of results still owed by the block.
// ----------------------------------------------------------------------------
package gpio_lcd_mirror_pkg;

   import gbl_pkg::*;

   localparam int MIRROR_PAGES   = 8;
   localparam int MIRROR_COLUMNS = 192;
   localparam int REPORT_LIMIT   = 10;

   class gpio_lcd_mirror;

      logic [7:0] cells [MIRROR_PAGES * MIRROR_COLUMNS];
      logic [7:0] page;
      logic [7:0] column;
      logic [7:0] saved_column;
      logic       rmw_active;
      logic       read_ready;
      logic       contrast_next;
      logic       panel_on;
      logic [5:0] contrast;
      phase_type  phase;
      logic [7:0] d_latch;
      logic [7:0] e_latch;
      logic [7:0] dir_ctrl;
      logic [7:0] d_pins;
      logic [7:0] e_pins;
      rsp_type    pending_results [$];
      int         failures;

      function new();
         failures = 0;
         foreach (cells[i]) cells[i] = 8'h00;
         page          = 8'd0;
         column        = 8'd0;
         saved_column  = 8'd0;
         rmw_active    = 1'b0;
         read_ready    = 1'b0;
         contrast_next = 1'b0;
         panel_on      = 1'b0;
         contrast      = CONTRAST_RESET;
         phase         = PH_IDLE;
         d_latch       = LATCH_RESET;
         e_latch       = LATCH_RESET;
         dir_ctrl      = DIR_RESET;
         remix();
      endfunction

      // Each bit of a two-bit code enables one nibble.
      function logic [7:0] code_mask(logic [1:0] code);
         return {{4{code[1]}}, {4{code[0]}}};
      endfunction

      // Input nibbles take the forced level, the others follow the latch.
      function void remix();
         logic [7:0] d_in;
         logic [7:0] e_in;
         d_in   = code_mask(dir_ctrl[1:0]);
         e_in   = code_mask(dir_ctrl[5:4]);
         d_pins = (code_mask(dir_ctrl[3:2]) & d_in) | (d_latch & ~d_in);
         e_pins = (code_mask(dir_ctrl[7:6]) & e_in) | (e_latch & ~e_in);
      endfunction

      function bit in_range();
         return (int'(page) < MIRROR_PAGES) && (int'(column) < MIRROR_COLUMNS);
      endfunction

      function int cell_index();
         return int'(page) * MIRROR_COLUMNS + int'(column);
      endfunction

      // Past the last column the address moves to column zero of the next page.
      function void step_column();
         if (int'(column) + 1 < MIRROR_COLUMNS) begin
            column = column + 8'd1;
         end else begin
            column = 8'd0;
            page   = page + 8'd1;
         end
      endfunction

      // A contrast command claims the following command byte as its value.
      function void run_command(logic [7:0] c);
         if (contrast_next) begin
            contrast      = c[5:0];
            contrast_next = 1'b0;
         end else if (c == CMD_CONTRAST) begin
            contrast_next = 1'b1;
         end else if (c[7:4] == CMD_GRP_PAGE) begin
            page       = {4'h0, c[3:0]};
            read_ready = 1'b0;
         end else if (c[7:4] == CMD_GRP_COL_HI) begin
            column     = {c[3:0], column[3:0]};
            read_ready = 1'b0;
         end else if (c[7:4] == CMD_GRP_COL_LO) begin
            column     = {column[7:4], c[3:0]};
            read_ready = 1'b0;
         end else if (c == CMD_DISPLAY_OFF || c == CMD_DISPLAY_ON) begin
            panel_on = (c == CMD_DISPLAY_ON);
         end else if (c == CMD_RMW_ENTER) begin
            saved_column = column;
            rmw_active   = 1'b1;
            read_ready   = 1'b0;
         end else if (c == CMD_RMW_EXIT && rmw_active) begin
            column     = saved_column;
            rmw_active = 1'b0;
            read_ready = 1'b0;
         end
      endfunction

      // Strobe decoder, stepped once for every port D write.
      function void advance_bus();
         logic [7:0] b;
         b = d_pins;
         case (phase)
            PH_IDLE: begin
               if (!b[BIT_SEL]) phase = PH_READY;
            end
            PH_READY: begin
               if (b[BIT_SEL]) begin
                  phase = PH_IDLE;
               end else if (b[BIT_DC]) begin
                  if (b[BIT_WR]) begin
                     if (!b[BIT_EN]) phase = PH_DATA_W;
                  end else if (b[BIT_EN]) begin
                     // The first read after an address change is a dummy one.
                     if (read_ready && in_range()) begin
                        e_pins = cells[cell_index()];
                        if (!rmw_active) step_column();
                     end
                     phase = PH_DATA_R;
                  end
               end else if (b[BIT_WR]) begin
                  if (!b[BIT_EN]) phase = PH_CMD_W;
               end else if (b[BIT_EN]) begin
                  e_pins = e_pins & ~STATUS_BUSY;
                  phase  = PH_STAT_R;
               end
            end
            PH_CMD_W: begin
               if (b[BIT_EN]) begin
                  run_command(e_pins);
                  phase = PH_READY;
               end
            end
            PH_STAT_R: begin
               if (b[BIT_WR]) phase = PH_READY;
            end
            PH_DATA_W: begin
               // Out-of-range writes are dropped but still move the column.
               if (!b[BIT_SEL] && b[BIT_DC] && b[BIT_WR] && b[BIT_EN]) begin
                  if (in_range()) cells[cell_index()] = e_pins;
                  step_column();
               end
               phase = PH_READY;
            end
            PH_DATA_R: begin
               if (b[BIT_WR]) begin
                  read_ready = 1'b1;
                  phase      = PH_READY;
               end
            end
            default: begin
               phase = PH_IDLE;
            end
         endcase
      endfunction

      // Apply one accepted register access and queue the result it owes.
      function void take_access(logic op, logic [1:0] sel, logic [7:0] wd);
         rsp_type want;
         want.read_data = 8'h00;
         if (op == OP_READ) begin
            if (sel == REG_PORT_D)
               want.read_data = d_pins;
            else if (sel == REG_DIR)
               want.read_data = dir_ctrl;
            else
               want.read_data = e_pins;
         end else if (sel == REG_PORT_E) begin
            e_latch = wd;
            remix();
         end else if (sel == REG_DIR) begin
            dir_ctrl = wd;
            remix();
         end else if (sel == REG_PORT_D) begin
            d_latch = wd;
            remix();
            advance_bus();
         end
         want.display_on     = panel_on;
         want.contrast_level = contrast;
         pending_results.push_back(want);
      endfunction

      // Compare one result transaction against the oldest owed result.
      function void match_result(logic [7:0] rd, logic on, logic [5:0] lvl);
         rsp_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected result read_data=%h display_on=%b contrast=%0d",
                        rd, on, lvl);
            return;
         end
         want = pending_results.pop_front();
         if (want.read_data !== rd || want.display_on !== on ||
             want.contrast_level !== lvl) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: expected read_data=%h display_on=%b contrast=%0d, %s%h %s%b %s%0d",
                        want.read_data, want.display_on, want.contrast_level,
                        "got read_data=", rd, "display_on=", on, "contrast=", lvl);
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives GPIO register accesses into the LCD controller core: a short
// directed pass over the strobe sequences, then random command, data and
// status transactions mixed with bus noise, with random idling on both
// channels. Every result is checked against the mirror model.
// ----------------------------------------------------------------------------
module testbench;

   import gbl_pkg::*;
   import gpio_lcd_mirror_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [7:0] DIR_PASS   = 8'h00;

   // Port D strobe patterns; select is active low.
   localparam logic [7:0] LCD_SELECT        = 8'h00;
   localparam logic [7:0] LCD_CMD_SETUP     = 8'h01;
   localparam logic [7:0] LCD_CMD_STROBE    = 8'h81;
   localparam logic [7:0] LCD_DATA_SETUP    = 8'h41;
   localparam logic [7:0] LCD_DATA_STROBE   = 8'hc1;
   localparam logic [7:0] LCD_READ_STROBE   = 8'hc0;
   localparam logic [7:0] LCD_READ_DONE     = 8'h01;
   localparam logic [7:0] LCD_STATUS_STROBE = 8'h80;

   localparam int DIRECTED_ITEMS = 26;
   localparam int RANDOM_ITEMS   = 950;
   localparam int TIMEOUT_CYCLES = 500000;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_operation       = 1'b0;
   logic [1:0] req_register_select = 2'd0;
   logic [7:0] req_write_data      = 8'h00;
   logic       rsp_stall           = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_display_on;
   logic [5:0] rsp_contrast_level;

   gpio_lcd_mirror mirror;
   int items_sent  = 0;
   int cycle_count = 0;
   int rx_hold     = 0;
   bit tx_quiet    = 1'b0;

   gpio_bitbang_lcd_controller_core #(
      .PAGE_COUNT   (MIRROR_PAGES),
      .COLUMN_COUNT (MIRROR_COLUMNS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_register_select (req_register_select),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_display_on      (rsp_display_on),
      .rsp_contrast_level  (rsp_contrast_level)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("gpio_bitbang_lcd_controller_core test failed");
      $finish;
   end

   // Result side: check each accepted transaction, then pick the next stall.
   // Windows recur in which no new stall is started.
   always @(posedge clock) begin
      bit hold;
      int roll;
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall)
         mirror.match_result(rsp_read_data, rsp_display_on, rsp_contrast_level);
      hold = 1'b0;
      if (rx_hold > 0) begin
         rx_hold--;
         hold = 1'b1;
      end else if ((cycle_count % 4000) >= 800) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            rx_hold = $urandom_range(0, 2);
            hold    = 1'b1;
         end else if (roll < 14) begin
            rx_hold = $urandom_range(8, 40);
            hold    = 1'b1;
         end
      end
      rsp_stall <= hold;
   end

   // One register access transaction, after an optional idle gap.
   task automatic send_access(input logic op, input logic [1:0] sel, input logic [7:0] wd);
      int gap;
      int roll;
      gap  = 0;
      roll = $urandom_range(0, 99);
      if (!tx_quiet) begin
         if (roll >= 95)
            gap = $urandom_range(8, 40);
         else if (roll >= 70)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_register_select <= sel;
      req_write_data      <= wd;
      do @(posedge clock); while (req_stall);
      mirror.take_access(op, sel, wd);
      items_sent++;
   endtask

   // Command byte on port E, then write setup and enable on port D.
   task automatic send_command(input logic [7:0] c);
      send_access(OP_WRITE, REG_PORT_E, c);
      send_access(OP_WRITE, REG_PORT_D, LCD_CMD_SETUP);
      send_access(OP_WRITE, REG_PORT_D, LCD_CMD_STROBE);
   endtask

   task automatic store_byte(input logic [7:0] v);
      send_access(OP_WRITE, REG_PORT_E, v);
      send_access(OP_WRITE, REG_PORT_D, LCD_DATA_SETUP);
      send_access(OP_WRITE, REG_PORT_D, LCD_DATA_STROBE);
   endtask

   // The fetched byte is visible on port E only until the next port D write.
   task automatic fetch_byte();
      send_access(OP_WRITE, REG_PORT_D, LCD_READ_STROBE);
      send_access(OP_READ, REG_PORT_E, 8'h00);
      send_access(OP_WRITE, REG_PORT_D, LCD_READ_DONE);
   endtask

   task automatic read_status();
      send_access(OP_WRITE, REG_PORT_D, LCD_STATUS_STROBE);
      send_access(OP_READ, REG_PORT_E, 8'h00);
      send_access(OP_WRITE, REG_PORT_D, LCD_READ_DONE);
   endtask

   // Hold off the request side until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int         kind;
      int         roll;
      int         waited;
      bit         mid_drained;
      logic [3:0] nib;
      logic [7:0] c;
      mid_drained = 1'b0;
      mirror      = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values, the unused select code and a few complete sequences.
      send_access(OP_READ, REG_PORT_D, 8'h00);
      send_access(OP_READ, REG_DIR, 8'h00);
      send_access(OP_READ, REG_PORT_E, 8'h00);
      send_access(OP_READ, REG_UNUSED, 8'h00);
      send_access(OP_WRITE, REG_UNUSED, 8'hff);
      send_access(OP_WRITE, REG_DIR, DIR_PASS);
      send_access(OP_WRITE, REG_PORT_D, LCD_SELECT);
      send_command(CMD_DISPLAY_ON);
      send_command(CMD_CONTRAST);
      send_command(8'hff);
      store_byte(8'h5a);
      read_status();
      send_access(OP_WRITE, REG_DIR, 8'hff);
      send_access(OP_READ, REG_PORT_D, 8'h00);
      send_access(OP_READ, REG_PORT_E, 8'h00);
      send_access(OP_WRITE, REG_DIR, DIR_PASS);

      // Random part: mostly well-formed LCD transactions, some noise.
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
         if ($urandom_range(0, 49) == 0 || (!mid_drained && items_sent >= 500)) begin
            drain_results();
            mid_drained = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 22) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               nib = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                    : $urandom_range(0, 7));
               c   = {CMD_GRP_PAGE, nib};
            end else if (roll < 30) begin
               nib = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                    : $urandom_range(0, 11));
               c   = {CMD_GRP_COL_HI, nib};
            end else if (roll < 45) begin
               nib = 4'($urandom_range(0, 15));
               c   = {CMD_GRP_COL_LO, nib};
            end else if (roll < 55) begin
               c = ($urandom_range(0, 1) == 1) ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF;
            end else if (roll < 62) begin
               c = CMD_RMW_ENTER;
            end else if (roll < 69) begin
               c = CMD_RMW_EXIT;
            end else if (roll < 80) begin
               c = CMD_CONTRAST;
            end else begin
               c = 8'($urandom_range(0, 255));
            end
            send_command(c);
            if (c == CMD_CONTRAST) send_command(8'($urandom_range(0, 255)));
         end else if (kind < 47) begin
            roll = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (roll) store_byte(8'($urandom_range(0, 255)));
         end else if (kind < 67) begin
            repeat ($urandom_range(1, 4)) fetch_byte();
         end else if (kind < 73) begin
            read_status();
         end else if (kind < 79) begin
            // Drop select with random other strobes, then select again.
            c          = 8'($urandom_range(0, 255));
            c[BIT_SEL] = 1'b1;
            send_access(OP_WRITE, REG_PORT_D, c);
            send_access(OP_WRITE, REG_PORT_D, LCD_SELECT);
         end else if (kind < 89) begin
            repeat ($urandom_range(1, 3))
               send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)));
            send_access(OP_WRITE, REG_DIR, DIR_PASS);
         end else if (kind < 94) begin
            // Forced pin levels seen through the port D, port E and unused read selects.
            send_access(OP_WRITE, REG_DIR, 8'($urandom_range(0, 255)));
            send_access(OP_READ, REG_PORT_D, 8'h00);
            send_access(OP_READ, REG_PORT_E, 8'h00);
            send_access(OP_READ, REG_UNUSED, 8'h00);
            send_access(OP_WRITE, REG_DIR, DIR_PASS);
         end else begin
            // In-range address, often near the end of a page, and a dummy read.
            nib = 4'($urandom_range(0, 7));
            send_command({CMD_GRP_PAGE, nib});
            if ($urandom_range(0, 3) == 0) begin
               send_command({CMD_GRP_COL_HI, 4'hb});
               nib = 4'($urandom_range(14, 15));
            end else begin
               nib = 4'($urandom_range(0, 11));
               send_command({CMD_GRP_COL_HI, nib});
               nib = 4'($urandom_range(0, 15));
            end
            send_command({CMD_GRP_COL_LO, nib});
            fetch_byte();
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (mirror.pending_results.size() != 0 && waited < 100000);
      repeat (8) @(posedge clock);
      if (mirror.pending_results.size() != 0) begin
         $display("ERROR: %0d results never arrived", mirror.pending_results.size());
         mirror.failures += mirror.pending_results.size();
      end
      if (mirror.failures == 0)
         $display("gpio_bitbang_lcd_controller_core test passed");
      else
         $display("gpio_bitbang_lcd_controller_core test failed");
      $finish;
   end

endmodule
